// ===== src/indexed_ordered_list_macros.svh =====
// assertion macros used by the ordered list datapath
// needs clk and rst_n in the scope of each use
`ifndef INDEXED_ORDERED_LIST_MACROS_SVH
`define INDEXED_ORDERED_LIST_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define IOL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed_ordered_list: assertion failed");
// next-cycle implication, checked out of reset
`define IOL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed_ordered_list: assertion failed");
`else
`define IOL_ASSERT_NOW(lbl, ante, cons)
`define IOL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/iol_pkg.sv =====
// shared types and constants of the ordered list block
// used by the interfaces, controller, datapath and top level
package iol_pkg;

  localparam int DEPTH  = 64;
  localparam int ELEM_W = 32;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int FPOS_W  = 6;
  localparam int ECNT_W  = 7;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int VX_W   = (ELEM_W > VAL_W) ? ELEM_W : VAL_W;
  localparam int CX_W   = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;
  localparam int FX_W   = (CNT_W > FPOS_W) ? CNT_W : FPOS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_READ      = 3'd2,
    CMD_OVERWRITE = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_POP       = 3'd5,
    CMD_FIND      = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_WR,
    S_DN_CAP,
    S_DN_RD,
    S_DN_WR,
    S_RD_WAIT,
    S_FIND_RD,
    S_FIND_CMP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic [1:0] {
    WA_COUNT,
    WA_POS,
    WA_IDX
  } wsel_t;

  typedef enum logic [1:0] {
    RA_POS,
    RA_IDX,
    RA_IDX_M1,
    RA_IDX_P1
  } rsel_t;

  typedef struct packed {
    logic    capture;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    logic    mem_we;
    wsel_t   wsel;
    logic    wd_rdata;
    rsel_t   rsel;
    logic    set_status;
    status_t status_code;
    logic    cap_rd;
    logic    set_found;
    logic    publish;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic full;
    logic idx_eq_pos;
    logic idx_last;
    logic idx_end;
    logic match;
    logic out_free;
  } sts_t;

endpackage

// ===== src/iol_in_if.sv =====
// command channel of the ordered list: valid/ready plus the command word
// depends on iol_pkg for field widths
interface iol_in_if;
  logic                        valid;
  logic                        ready;
  logic [iol_pkg::CMD_W-1:0]   cmd;
  logic [iol_pkg::POS_W-1:0]   position;
  logic [iol_pkg::VAL_W-1:0]   item_value;

  modport source (output valid, cmd, position, item_value, input ready);
  modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

// ===== src/iol_out_if.sv =====
// result channel of the ordered list: valid/ready plus the result word
// depends on iol_pkg for field widths
interface iol_out_if;
  logic                        valid;
  logic                        ready;
  logic [iol_pkg::STAT_W-1:0]  status;
  logic [iol_pkg::VAL_W-1:0]   read_value;
  logic                        found;
  logic [iol_pkg::FPOS_W-1:0]  found_position;
  logic [iol_pkg::ECNT_W-1:0]  entry_count;
  logic                        is_empty;

  modport source (output valid, status, read_value, found, found_position,
                  entry_count, is_empty, input ready);
  modport sink   (input valid, status, read_value, found, found_position,
                  entry_count, is_empty, output ready);
endinterface

// ===== src/iol_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module iol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/iol_ctrl.sv =====
// controller of the ordered list: sequences shifts, scans and result hand-off
// depends on iol_pkg for state, command and control types
module iol_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  iol_pkg::sts_t sts,
  output iol_pkg::ctl_t ctl
);

  iol_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iol_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iol_pkg::S_IDLE: begin
        if (accept) state_nxt = iol_pkg::S_DECODE;
      end
      iol_pkg::S_DECODE: begin
        case (sts.cmd)
          iol_pkg::CMD_INSERT: begin
            if (sts.pos_gt_cnt || sts.full) state_nxt = iol_pkg::S_DONE;
            else state_nxt = iol_pkg::S_UP_RD;
          end
          iol_pkg::CMD_READ: begin
            if (sts.pos_ge_cnt) state_nxt = iol_pkg::S_DONE;
            else state_nxt = iol_pkg::S_RD_WAIT;
          end
          iol_pkg::CMD_REMOVE, iol_pkg::CMD_POP: begin
            if (sts.pos_ge_cnt) state_nxt = iol_pkg::S_DONE;
            else state_nxt = iol_pkg::S_DN_CAP;
          end
          iol_pkg::CMD_FIND: state_nxt = iol_pkg::S_FIND_RD;
          default:           state_nxt = iol_pkg::S_DONE;
        endcase
      end
      iol_pkg::S_UP_RD: begin
        if (sts.idx_eq_pos) state_nxt = iol_pkg::S_DONE;
        else state_nxt = iol_pkg::S_UP_WR;
      end
      iol_pkg::S_UP_WR:   state_nxt = iol_pkg::S_UP_RD;
      iol_pkg::S_DN_CAP:  state_nxt = iol_pkg::S_DN_RD;
      iol_pkg::S_DN_RD: begin
        if (sts.idx_last) state_nxt = iol_pkg::S_DONE;
        else state_nxt = iol_pkg::S_DN_WR;
      end
      iol_pkg::S_DN_WR:   state_nxt = iol_pkg::S_DN_RD;
      iol_pkg::S_RD_WAIT: state_nxt = iol_pkg::S_DONE;
      iol_pkg::S_FIND_RD: begin
        if (sts.idx_end) state_nxt = iol_pkg::S_DONE;
        else state_nxt = iol_pkg::S_FIND_CMP;
      end
      iol_pkg::S_FIND_CMP: begin
        if (sts.match) state_nxt = iol_pkg::S_DONE;
        else state_nxt = iol_pkg::S_FIND_RD;
      end
      iol_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = iol_pkg::S_IDLE;
      end
      default: state_nxt = iol_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = 1'b0;
    ctl.capture     = 1'b0;
    ctl.idx_op      = iol_pkg::IDX_HOLD;
    ctl.cnt_op      = iol_pkg::CNT_HOLD;
    ctl.mem_we      = 1'b0;
    ctl.wsel        = iol_pkg::WA_IDX;
    ctl.wd_rdata    = 1'b0;
    ctl.rsel        = iol_pkg::RA_POS;
    ctl.set_status  = 1'b0;
    ctl.status_code = iol_pkg::STAT_OK;
    ctl.cap_rd      = 1'b0;
    ctl.set_found   = 1'b0;
    ctl.publish     = 1'b0;
    case (state_r)
      iol_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = accept;
      end
      iol_pkg::S_DECODE: begin
        case (sts.cmd)
          iol_pkg::CMD_APPEND: begin
            if (sts.full) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = iol_pkg::STAT_FULL;
            end else begin
              ctl.mem_we = 1'b1;
              ctl.wsel   = iol_pkg::WA_COUNT;
              ctl.cnt_op = iol_pkg::CNT_INC;
            end
          end
          iol_pkg::CMD_INSERT: begin
            // position check wins over the full check
            if (sts.pos_gt_cnt) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = iol_pkg::STAT_BAD_POS;
            end else if (sts.full) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = iol_pkg::STAT_FULL;
            end else begin
              ctl.idx_op = iol_pkg::IDX_COUNT;
            end
          end
          iol_pkg::CMD_READ, iol_pkg::CMD_REMOVE, iol_pkg::CMD_POP: begin
            if (sts.pos_ge_cnt) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = iol_pkg::STAT_BAD_POS;
            end else begin
              ctl.rsel   = iol_pkg::RA_POS;
              ctl.idx_op = iol_pkg::IDX_POS;
            end
          end
          iol_pkg::CMD_OVERWRITE: begin
            if (sts.pos_ge_cnt) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = iol_pkg::STAT_BAD_POS;
            end else begin
              ctl.mem_we = 1'b1;
              ctl.wsel   = iol_pkg::WA_POS;
            end
          end
          iol_pkg::CMD_FIND:  ctl.idx_op = iol_pkg::IDX_ZERO;
          iol_pkg::CMD_CLEAR: ctl.cnt_op = iol_pkg::CNT_CLR;
          default: ;
        endcase
      end
      iol_pkg::S_UP_RD: begin
        if (sts.idx_eq_pos) begin
          // gap opened: drop the new word in
          ctl.mem_we = 1'b1;
          ctl.wsel   = iol_pkg::WA_POS;
          ctl.cnt_op = iol_pkg::CNT_INC;
        end else begin
          ctl.rsel = iol_pkg::RA_IDX_M1;
        end
      end
      iol_pkg::S_UP_WR: begin
        ctl.mem_we   = 1'b1;
        ctl.wsel     = iol_pkg::WA_IDX;
        ctl.wd_rdata = 1'b1;
        ctl.idx_op   = iol_pkg::IDX_DEC;
      end
      iol_pkg::S_DN_CAP: begin
        ctl.cap_rd = (sts.cmd == iol_pkg::CMD_POP);
      end
      iol_pkg::S_DN_RD: begin
        if (sts.idx_last) ctl.cnt_op = iol_pkg::CNT_DEC;
        else ctl.rsel = iol_pkg::RA_IDX_P1;
      end
      iol_pkg::S_DN_WR: begin
        ctl.mem_we   = 1'b1;
        ctl.wsel     = iol_pkg::WA_IDX;
        ctl.wd_rdata = 1'b1;
        ctl.idx_op   = iol_pkg::IDX_INC;
      end
      iol_pkg::S_RD_WAIT: ctl.cap_rd = 1'b1;
      iol_pkg::S_FIND_RD: ctl.rsel = iol_pkg::RA_IDX;
      iol_pkg::S_FIND_CMP: begin
        if (sts.match) ctl.set_found = 1'b1;
        else ctl.idx_op = iol_pkg::IDX_INC;
      end
      iol_pkg::S_DONE: ctl.publish = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/iol_dp.sv =====
// datapath of the ordered list: entry store, count, index counter, result registers
// depends on iol_pkg, iol_ram and the assertion macros
`include "indexed_ordered_list_macros.svh"

module iol_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [iol_pkg::CMD_W-1:0]    in_cmd,
  input  logic [iol_pkg::POS_W-1:0]    in_position,
  input  logic [iol_pkg::VAL_W-1:0]    in_item_value,
  input  iol_pkg::ctl_t                ctl,
  output iol_pkg::sts_t                sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [iol_pkg::STAT_W-1:0]   out_status,
  output logic [iol_pkg::VAL_W-1:0]    out_read_value,
  output logic                         out_found,
  output logic [iol_pkg::FPOS_W-1:0]   out_found_position,
  output logic [iol_pkg::ECNT_W-1:0]   out_entry_count,
  output logic                         out_is_empty
);

  localparam int CNT_W  = iol_pkg::CNT_W;
  localparam int ADDR_W = iol_pkg::ADDR_W;
  localparam int CMP_W  = iol_pkg::CMP_W;
  localparam int ELEM_W = iol_pkg::ELEM_W;

  // captured command word
  iol_pkg::cmd_t               cmd_r;
  logic [iol_pkg::POS_W-1:0]   pos_r;
  logic [ELEM_W-1:0]           val_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;

  // working result
  iol_pkg::status_t  stat_r;
  logic [ELEM_W-1:0] rd_r;
  logic              found_r;
  logic [CNT_W-1:0]  fpos_r;

  // output register
  logic                        out_valid_r;
  logic [iol_pkg::STAT_W-1:0]  out_status_r;
  logic [iol_pkg::VAL_W-1:0]   out_read_value_r;
  logic                        out_found_r;
  logic [iol_pkg::FPOS_W-1:0]  out_found_position_r;
  logic [iol_pkg::ECNT_W-1:0]  out_entry_count_r;
  logic                        out_is_empty_r;

  logic [iol_pkg::VX_W-1:0] val_x;
  logic [iol_pkg::VX_W-1:0] rd_x;
  logic [iol_pkg::CX_W-1:0] cnt_x;
  logic [iol_pkg::FX_W-1:0] fpos_x;

  logic [CMP_W-1:0]  pos_c, cnt_c, idx_c;
  logic [CNT_W-1:0]  idx_p1, idx_m1;
  logic [ADDR_W-1:0] pos_a, waddr, raddr;
  logic [ELEM_W-1:0] wdata, rdata;
  logic              out_free;

  assign val_x  = iol_pkg::VX_W'(in_item_value);
  assign pos_c  = CMP_W'(pos_r);
  assign cnt_c  = CMP_W'(count_r);
  assign idx_c  = CMP_W'(idx_r);
  assign idx_p1 = idx_r + 1'b1;
  assign idx_m1 = idx_r - 1'b1;
  assign pos_a  = pos_c[ADDR_W-1:0];
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (ctl.wsel)
      iol_pkg::WA_COUNT: waddr = count_r[ADDR_W-1:0];
      iol_pkg::WA_POS:   waddr = pos_a;
      default:           waddr = idx_r[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    case (ctl.rsel)
      iol_pkg::RA_IDX:    raddr = idx_r[ADDR_W-1:0];
      iol_pkg::RA_IDX_M1: raddr = idx_m1[ADDR_W-1:0];
      iol_pkg::RA_IDX_P1: raddr = idx_p1[ADDR_W-1:0];
      default:            raddr = pos_a;
    endcase
  end

  assign wdata = ctl.wd_rdata ? rdata : val_r;

  iol_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (iol_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.cmd        = cmd_r;
    sts.pos_gt_cnt = pos_c > cnt_c;
    sts.pos_ge_cnt = pos_c >= cnt_c;
    sts.full       = count_r == CNT_W'(iol_pkg::DEPTH);
    sts.idx_eq_pos = idx_c == pos_c;
    sts.idx_last   = idx_p1 >= count_r;
    sts.idx_end    = idx_r >= count_r;
    sts.match      = rdata == val_r;
    sts.out_free   = out_free;
  end

  always_comb begin
    case (ctl.cnt_op)
      iol_pkg::CNT_INC: count_nxt = count_r + 1'b1;
      iol_pkg::CNT_DEC: count_nxt = count_r - 1'b1;
      iol_pkg::CNT_CLR: count_nxt = '0;
      default:          count_nxt = count_r;
    endcase
  end

  always_comb begin
    case (ctl.idx_op)
      iol_pkg::IDX_COUNT: idx_nxt = count_r;
      iol_pkg::IDX_POS:   idx_nxt = pos_c[CNT_W-1:0];
      iol_pkg::IDX_ZERO:  idx_nxt = '0;
      iol_pkg::IDX_INC:   idx_nxt = idx_p1;
      iol_pkg::IDX_DEC:   idx_nxt = idx_m1;
      default:            idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (ctl.publish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.capture) begin
      cmd_r   <= iol_pkg::cmd_t'(in_cmd);
      pos_r   <= in_position;
      val_r   <= val_x[ELEM_W-1:0];
      stat_r  <= iol_pkg::STAT_OK;
      rd_r    <= '0;
      found_r <= 1'b0;
      fpos_r  <= '0;
    end else begin
      if (ctl.set_status) stat_r <= ctl.status_code;
      if (ctl.cap_rd) rd_r <= rdata;
      if (ctl.set_found) begin
        found_r <= 1'b1;
        fpos_r  <= idx_r;
      end
    end
  end

  // count is already final when the word is published
  assign rd_x   = iol_pkg::VX_W'(rd_r);
  assign cnt_x  = iol_pkg::CX_W'(count_r);
  assign fpos_x = iol_pkg::FX_W'(fpos_r);

  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      out_status_r         <= stat_r;
      out_read_value_r     <= rd_x[iol_pkg::VAL_W-1:0];
      out_found_r          <= found_r;
      out_found_position_r <= fpos_x[iol_pkg::FPOS_W-1:0];
      out_entry_count_r    <= cnt_x[iol_pkg::ECNT_W-1:0];
      out_is_empty_r       <= count_r == '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_read_value_r;
  assign out_found          = out_found_r;
  assign out_found_position = out_found_position_r;
  assign out_entry_count    = out_entry_count_r;
  assign out_is_empty       = out_is_empty_r;

  `IOL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(iol_pkg::DEPTH))
  `IOL_ASSERT_NOW(a_inc_not_full, ctl.cnt_op == iol_pkg::CNT_INC,
                  count_r < CNT_W'(iol_pkg::DEPTH))
  `IOL_ASSERT_NOW(a_shift_in_list, ctl.mem_we && ctl.wsel == iol_pkg::WA_IDX,
                  idx_r <= count_r && idx_r < CNT_W'(iol_pkg::DEPTH))
  `IOL_ASSERT_NOW(a_publish_free, ctl.publish, !out_valid_r || out_ready)
  `IOL_ASSERT_NEXT(a_publish_valid, ctl.publish, out_valid_r)

endmodule

// ===== src/indexed_ordered_list.sv =====
// result word registered when the command completes; append, overwrite, clear and errors
//   complete on decode, read waits on the ram, insert moves the entries from the position on
//   up, remove and pop move the entries above it down, find scans until a match or the end
// throughput: one command at a time, next word accepted the cycle after the result is
//   registered, later while an earlier result still waits on out ready
// reset: synchronous active-low, count cleared; entry ram is not cleared (no sweep)
module indexed_ordered_list (
  input  logic      clk,
  input  logic      rst_n,
  iol_in_if.sink    in_ch,
  iol_out_if.source out_ch
);

  iol_pkg::ctl_t ctl;
  iol_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  iol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  iol_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_ch.cmd),
    .in_position        (in_ch.position),
    .in_item_value      (in_ch.item_value),
    .ctl                (ctl),
    .sts                (sts),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_read_value     (out_ch.read_value),
    .out_found          (out_ch.found),
    .out_found_position (out_ch.found_position),
    .out_entry_count    (out_ch.entry_count),
    .out_is_empty       (out_ch.is_empty)
  );

endmodule

// ===== tb/indexed_ordered_list_tb.sv =====
`timescale 1ns / 1ps
// testbench for indexed_ordered_list: a directed table, then random command words
// checked field by field against a behavioural list kept alongside the block
// depends on iol_pkg, iol_in_if, iol_out_if and the indexed_ordered_list top level
module indexed_ordered_list_tb;

  localparam int RANDOM_ITEMS = 1525;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int TIMEOUT_NS   = 10_000_000;

  typedef enum int {
    MODE_FILL,
    MODE_MIXED,
    MODE_DRAIN
  } mix_mode_t;

  typedef struct packed {
    iol_pkg::status_t                   status;
    logic [iol_pkg::VAL_W-1:0]          read_value;
    logic                               found;
    logic [iol_pkg::FPOS_W-1:0]         found_position;
    logic [iol_pkg::ECNT_W-1:0]         entry_count;
    logic                               is_empty;
  } list_result_t;

  typedef struct {
    iol_pkg::cmd_t               cmd;
    logic [iol_pkg::POS_W-1:0]   position;
    logic [iol_pkg::VAL_W-1:0]   item_value;
    bit                          typed;
    list_result_t                want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  iol_in_if  cmd_if ();
  iol_out_if res_if ();

  indexed_ordered_list i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (res_if)
  );

  // behavioural copy of the list
  logic [iol_pkg::ELEM_W-1:0] list_mem [iol_pkg::DEPTH];
  int                         list_count;

  list_result_t pending_results [$];
  stim_row_t    directed_rows [$];
  int           mismatches;
  int           results_seen;
  int           words_accepted;
  int           burst_left;
  logic         hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("** indexed_ordered_list: FAILED **");
    $finish;
  end

  function automatic list_result_t list_step(input iol_pkg::cmd_t c,
                                             input logic [iol_pkg::POS_W-1:0] p,
                                             input logic [iol_pkg::VAL_W-1:0] v);
    list_result_t r;
    int           i;
    r = '0;
    r.status = iol_pkg::STAT_OK;
    case (c)
      iol_pkg::CMD_APPEND: begin
        if (list_count >= iol_pkg::DEPTH) begin
          r.status = iol_pkg::STAT_FULL;
        end else begin
          list_mem[list_count] = v[iol_pkg::ELEM_W-1:0];
          list_count++;
        end
      end
      iol_pkg::CMD_INSERT: begin
        // position check wins over the full check
        if (int'(p) > list_count) begin
          r.status = iol_pkg::STAT_BAD_POS;
        end else if (list_count >= iol_pkg::DEPTH) begin
          r.status = iol_pkg::STAT_FULL;
        end else begin
          for (i = list_count; i > int'(p); i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = v[iol_pkg::ELEM_W-1:0];
          list_count++;
        end
      end
      iol_pkg::CMD_READ: begin
        if (int'(p) < list_count) r.read_value = iol_pkg::VAL_W'(list_mem[p]);
        else r.status = iol_pkg::STAT_BAD_POS;
      end
      iol_pkg::CMD_OVERWRITE: begin
        if (int'(p) < list_count) list_mem[p] = v[iol_pkg::ELEM_W-1:0];
        else r.status = iol_pkg::STAT_BAD_POS;
      end
      iol_pkg::CMD_REMOVE, iol_pkg::CMD_POP: begin
        if (int'(p) < list_count) begin
          if (c == iol_pkg::CMD_POP) r.read_value = iol_pkg::VAL_W'(list_mem[p]);
          for (i = int'(p); i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
        end else begin
          r.status = iol_pkg::STAT_BAD_POS;
        end
      end
      iol_pkg::CMD_FIND: begin
        for (i = 0; i < list_count && !r.found; i++) begin
          if (list_mem[i] == v[iol_pkg::ELEM_W-1:0]) begin
            r.found = 1'b1;
            r.found_position = iol_pkg::FPOS_W'(i);
          end
        end
      end
      default: list_count = 0;
    endcase
    r.entry_count = iol_pkg::ECNT_W'(list_count);
    r.is_empty = (list_count == 0);
    return r;
  endfunction

  function automatic stim_row_t row(input iol_pkg::cmd_t c, input int p,
                                    input logic [iol_pkg::VAL_W-1:0] v);
    stim_row_t s;
    s.cmd = c;
    s.position = iol_pkg::POS_W'(p);
    s.item_value = v;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  // rows whose answer is plain: nothing read, nothing found
  function automatic stim_row_t row_exp(input iol_pkg::cmd_t c, input int p,
                                        input logic [iol_pkg::VAL_W-1:0] v,
                                        input iol_pkg::status_t st, input int cnt);
    stim_row_t s;
    s = row(c, p, v);
    s.typed = 1'b1;
    s.want.status = st;
    s.want.entry_count = iol_pkg::ECNT_W'(cnt);
    s.want.is_empty = (cnt == 0);
    return s;
  endfunction

  function automatic iol_pkg::cmd_t pick_cmd(input mix_mode_t mode);
    int w [8];
    int roll;
    int acc;
    case (mode)
      MODE_FILL:  w = '{35, 35, 8, 6, 5, 5, 6, 0};
      MODE_DRAIN: w = '{5, 5, 8, 6, 35, 30, 10, 1};
      default:    w = '{18, 18, 14, 10, 14, 12, 12, 2};
    endcase
    roll = $urandom_range(0, 99);
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      acc += w[i];
      if (roll < acc) return iol_pkg::cmd_t'(i);
    end
    return iol_pkg::CMD_FIND;
  endfunction

  function automatic logic [iol_pkg::POS_W-1:0] pick_pos(input iol_pkg::cmd_t c);
    int lim;
    lim = (c == iol_pkg::CMD_INSERT) ? list_count + 1 : list_count;
    if (lim > 0 && $urandom_range(0, 99) < 88) begin
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return iol_pkg::POS_W'(lim - 1);
        default: return iol_pkg::POS_W'($urandom_range(0, lim - 1));
      endcase
    end
    return iol_pkg::POS_W'($urandom_range(lim, (1 << iol_pkg::POS_W) - 1));
  endfunction

  function automatic logic [iol_pkg::VAL_W-1:0] pick_val(input iol_pkg::cmd_t c);
    // searches mostly look for something that is there
    if (c == iol_pkg::CMD_FIND && list_count > 0 && $urandom_range(0, 99) < 60)
      return iol_pkg::VAL_W'(list_mem[$urandom_range(0, list_count - 1)]);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return iol_pkg::VAL_W'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [iol_pkg::VAL_W-1:0] got,
                                 input logic [iol_pkg::VAL_W-1:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    list_result_t e;
    if (pending_results.size() == 0) begin
      report_mismatch("unrequested word", '0, '0);
      return;
    end
    e = pending_results.pop_front();
    if (res_if.status !== e.status)
      report_mismatch("status", iol_pkg::VAL_W'(res_if.status), iol_pkg::VAL_W'(e.status));
    if (res_if.read_value !== e.read_value)
      report_mismatch("read_value", res_if.read_value, e.read_value);
    if (res_if.found !== e.found)
      report_mismatch("found", iol_pkg::VAL_W'(res_if.found), iol_pkg::VAL_W'(e.found));
    if (res_if.found_position !== e.found_position)
      report_mismatch("found_position", iol_pkg::VAL_W'(res_if.found_position),
                      iol_pkg::VAL_W'(e.found_position));
    if (res_if.entry_count !== e.entry_count)
      report_mismatch("entry_count", iol_pkg::VAL_W'(res_if.entry_count),
                      iol_pkg::VAL_W'(e.entry_count));
    if (res_if.is_empty !== e.is_empty)
      report_mismatch("is_empty", iol_pkg::VAL_W'(res_if.is_empty),
                      iol_pkg::VAL_W'(e.is_empty));
  endtask

  task automatic offer_word(input iol_pkg::cmd_t c, input logic [iol_pkg::POS_W-1:0] p,
                            input logic [iol_pkg::VAL_W-1:0] v, input bit typed,
                            input list_result_t want);
    list_result_t r;
    if (burst_left == 0) begin
      // drop valid for a gap so valid is never lowered and raised in one step
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
    end
    burst_left--;
    cmd_if.valid <= 1'b1;
    cmd_if.cmd <= c;
    cmd_if.position <= p;
    cmd_if.item_value <= v;
    @(posedge clk);
    while (cmd_if.ready !== 1'b1) @(posedge clk);
    r = list_step(c, p, v);
    pending_results.push_back(typed ? want : r);
    words_accepted++;
  endtask

  initial begin : result_sink
    int   mode;
    int   mode_left;
    int   phase;
    logic rdy;
    res_if.ready <= 1'b0;
    mode = 0;
    mode_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        check_result();
        results_seen++;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      phase = (phase + 1) % 7;
      case (mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 9) < 7);
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (phase != 2 && phase != 3);
      endcase
      if (hold_off) rdy = 1'b0;
      res_if.ready <= rdy;
    end
  end

  // one long stall of the receiver while the sender keeps offering words
  initial begin : long_hold
    hold_off <= 1'b0;
    wait (words_accepted >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    mix_mode_t                 mode;
    int                        seg_left;
    iol_pkg::cmd_t             c;
    logic [iol_pkg::POS_W-1:0] p;
    logic [iol_pkg::VAL_W-1:0] v;
    rst_n <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.cmd <= iol_pkg::CMD_APPEND;
    cmd_if.position <= '0;
    cmd_if.item_value <= '0;
    mismatches = 0;
    results_seen = 0;
    words_accepted = 0;
    burst_left = 0;
    list_count = 0;
    foreach (list_mem[i]) list_mem[i] = '0;

    directed_rows.push_back(row_exp(iol_pkg::CMD_READ, 0, 32'h0, iol_pkg::STAT_BAD_POS, 0));
    directed_rows.push_back(row_exp(iol_pkg::CMD_FIND, 0, 32'h0, iol_pkg::STAT_OK, 0));
    directed_rows.push_back(row_exp(iol_pkg::CMD_REMOVE, 0, 32'h0, iol_pkg::STAT_BAD_POS, 0));
    directed_rows.push_back(row_exp(iol_pkg::CMD_INSERT, 1, 32'h1, iol_pkg::STAT_BAD_POS, 0));
    directed_rows.push_back(row_exp(iol_pkg::CMD_APPEND, 0, 32'hFFFF_FFFF, iol_pkg::STAT_OK, 1));
    directed_rows.push_back(row_exp(iol_pkg::CMD_APPEND, 0, 32'h0, iol_pkg::STAT_OK, 2));
    directed_rows.push_back(row_exp(iol_pkg::CMD_INSERT, 3, 32'h2, iol_pkg::STAT_BAD_POS, 2));
    directed_rows.push_back(row(iol_pkg::CMD_INSERT, 2, 32'h5A5A_5A5A));
    directed_rows.push_back(row(iol_pkg::CMD_INSERT, 0, 32'h8000_0001));
    directed_rows.push_back(row_exp(iol_pkg::CMD_READ, 127, 32'h0, iol_pkg::STAT_BAD_POS, 4));
    directed_rows.push_back(row_exp(iol_pkg::CMD_OVERWRITE, 64, 32'h1,
                                    iol_pkg::STAT_BAD_POS, 4));
    directed_rows.push_back(row(iol_pkg::CMD_OVERWRITE, 1, 32'h1234_5678));
    directed_rows.push_back(row(iol_pkg::CMD_READ, 0, 32'h0));
    directed_rows.push_back(row(iol_pkg::CMD_FIND, 0, 32'h0));
    directed_rows.push_back(row(iol_pkg::CMD_FIND, 0, 32'hDEAD_BEEF));
    directed_rows.push_back(row(iol_pkg::CMD_POP, 2, 32'h0));
    directed_rows.push_back(row_exp(iol_pkg::CMD_REMOVE, 3, 32'h0, iol_pkg::STAT_BAD_POS, 3));
    directed_rows.push_back(row(iol_pkg::CMD_REMOVE, 0, 32'h0));
    directed_rows.push_back(row(iol_pkg::CMD_POP, 1, 32'h0));
    directed_rows.push_back(row_exp(iol_pkg::CMD_POP, 1, 32'h0, iol_pkg::STAT_BAD_POS, 1));
    directed_rows.push_back(row(iol_pkg::CMD_POP, 0, 32'h0));
    directed_rows.push_back(row(iol_pkg::CMD_APPEND, 0, 32'h7));
    directed_rows.push_back(row_exp(iol_pkg::CMD_CLEAR, 0, 32'h0, iol_pkg::STAT_OK, 0));
    directed_rows.push_back(row_exp(iol_pkg::CMD_CLEAR, 127, 32'hFFFF_FFFF,
                                    iol_pkg::STAT_OK, 0));
    // stale entry left behind by clear must stay invisible
    directed_rows.push_back(row_exp(iol_pkg::CMD_FIND, 0, 32'h7, iol_pkg::STAT_OK, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].cmd, directed_rows[i].position, directed_rows[i].item_value,
                 directed_rows[i].typed, directed_rows[i].want);

    // opening fill segment weights appends and inserts to grow the list toward full
    mode = MODE_FILL;
    seg_left = 100;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        mode = mix_mode_t'($urandom_range(0, 2));
        seg_left = $urandom_range(40, 160);
      end
      seg_left--;
      if ($urandom_range(0, 99) < 8) begin
        c = iol_pkg::cmd_t'($urandom_range(0, 7));
        p = iol_pkg::POS_W'($urandom_range(0, (1 << iol_pkg::POS_W) - 1));
        v = $urandom();
      end else begin
        c = pick_cmd(mode);
        p = pick_pos(c);
        v = pick_val(c);
      end
      offer_word(c, p, v, 1'b0, '0);
    end
    cmd_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** indexed_ordered_list: PASSED **");
    end else begin
      $display("** indexed_ordered_list: FAILED **");
    end
    $finish;
  end

endmodule
